### rtl/stsg_pkg.sv
// ----------------------------------------------------------------------------
// Stepper trapezoid step generator package
// Register indexes, register reset values and field widths shared by the
// step generator and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package stsg_pkg;

    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned SHIFT_W     = 4;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned POS_PORT_W  = 32;

    typedef logic [PERIOD_W-1:0]    period_t;
    typedef logic [SHIFT_W-1:0]     shift_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SLOWEST_PERIOD = 3'd0;
    localparam cfg_index_t REG_CRUISE_PERIOD  = 3'd1;
    localparam cfg_index_t REG_PERIOD_STEP    = 3'd2;
    localparam cfg_index_t REG_BRAKE_SHIFT    = 3'd3;
    localparam cfg_index_t REG_STOP_WINDOW    = 3'd4;

    localparam period_t RST_SLOWEST_PERIOD = 16'd2000;
    localparam period_t RST_CRUISE_PERIOD  = 16'd200;
    localparam period_t RST_PERIOD_STEP    = 16'd4;
    localparam shift_t  RST_BRAKE_SHIFT    = 4'd2;
    localparam period_t RST_STOP_WINDOW    = 16'd0;

    // Smallest usable period; a zero slowest or cruise period is raised to it.
    localparam period_t MIN_PERIOD = 16'd1;

endpackage

`default_nettype wire

### rtl/stepper_trapezoid_step_generator.sv
// ----------------------------------------------------------------------------
// Stepper trapezoid step generator
// Trapezoidal speed ramp with two-phase quadrature step outputs, driven by
// one step-timer expiry per request.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request is either a timer tick carrying the target position
//   (s_kind = 0) or a preset that loads the current position (s_kind = 1).
//   Every request yields exactly one result on the m_ channel: the timer
//   reload for the next interval, the quadrature levels, the step flag, the
//   direction, the commanded position and the at-rest flag.
//   The result is registered: it is loaded at the edge that accepts the
//   request. Throughput is one request per cycle unless the receiver stalls;
//   the ramp state (period, direction, phases, position) is updated in the
//   same edge that loads the result register; the next request sees it at once.
//   When the receiver stalls, the result register holds its value and
//   s_ready stays high only if the held result is taken in that cycle.
//   Configuration writes on the cfg_ channel are always accepted and should
//   only be made while no result is pending.
//   Reset empties the result register and restores the configuration registers
//   and the ramp state to their defaults (period at the slowest period, forward).
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_step_generator
    import stsg_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_kind,
    input  wire logic signed [31:0]       s_position,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [15:0]                   m_next_period,
    output logic                          m_phase_a,
    output logic                          m_phase_b,
    output logic                          m_stepped,
    output logic                          m_moving_forward,
    output logic signed [31:0]            m_current_position,
    output logic                          m_at_rest,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Configuration registers
    period_t slowest_reg, cruise_reg, step_reg, window_reg;
    shift_t  shift_reg;

    // Ramp state
    pos_t    pos_reg,    pos_next;
    period_t period_reg, period_next;
    logic    dir_reg,    dir_next;
    logic    pha_reg,    pha_next;
    logic    phb_reg,    phb_next;

    // Result register
    logic    m_valid_reg;
    period_t out_period_reg;
    logic    out_pha_reg, out_phb_reg, out_stepped_reg, out_dir_reg, out_rest_reg;
    logic signed [31:0] out_pos_reg;

    logic    s_accept;
    period_t slow_eff, cruise_raw, cruise_eff, dep;
    pos_t    target, stop_pos, dis, dep_ext;
    logic [PERIOD_W:0] cruise_plus_step, period_plus_step;
    logic    rest, stepped, toward, far;
    logic signed [63:0] target_wide, pos_wide;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slowest_reg <= RST_SLOWEST_PERIOD;
            cruise_reg  <= RST_CRUISE_PERIOD;
            step_reg    <= RST_PERIOD_STEP;
            shift_reg   <= RST_BRAKE_SHIFT;
            window_reg  <= RST_STOP_WINDOW;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SLOWEST_PERIOD: slowest_reg <= cfg_data;
                REG_CRUISE_PERIOD:  cruise_reg  <= cfg_data;
                REG_PERIOD_STEP:    step_reg    <= cfg_data;
                REG_BRAKE_SHIFT:    shift_reg   <= cfg_data[SHIFT_W-1:0];
                REG_STOP_WINDOW:    window_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        slow_eff   = (slowest_reg == '0) ? MIN_PERIOD : slowest_reg;
        cruise_raw = (cruise_reg == '0) ? MIN_PERIOD : cruise_reg;
        cruise_eff = (cruise_raw > slow_eff) ? slow_eff : cruise_raw;

        target_wide = 64'(s_position);
        target      = target_wide[POSITION_BITS-1:0];

        // Braking distance saturates to zero when the period is above slowest.
        dep      = (period_reg < slow_eff) ? period_t'((slow_eff - period_reg) >> shift_reg)
                                           : '0;
        dep_ext  = POSITION_BITS'(dep);
        stop_pos = dir_reg ? (pos_reg + dep_ext) : (pos_reg - dep_ext);
        dis      = target - stop_pos;

        cruise_plus_step = {1'b0, cruise_eff} + {1'b0, step_reg};
        period_plus_step = {1'b0, period_reg} + {1'b0, step_reg};
        toward = (dis[POSITION_BITS-1] == !dir_reg);
        far    = (dis != '0) && (dis != pos_t'(1)) && (dis != '1);

        pos_next    = pos_reg;
        period_next = period_reg;
        dir_next    = dir_reg;
        pha_next    = pha_reg;
        phb_next    = phb_reg;
        rest        = 1'b0;
        stepped     = 1'b0;

        if (s_kind) begin
            pos_next = target;
        end else if (target == pos_reg && dep <= window_reg) begin
            period_next = slow_eff;
            rest        = 1'b1;
        end else begin
            if (toward) begin
                if ({1'b0, period_reg} > cruise_plus_step) begin
                    if (far) begin
                        period_next = period_reg - step_reg;
                    end
                end else begin
                    period_next = cruise_eff;
                end
            end else begin
                // Reverse only once the motor has slowed to standstill speed.
                if (period_reg == slow_eff) begin
                    dir_next = !dir_reg;
                end
                if (period_plus_step < {1'b0, slow_eff}) begin
                    period_next = period_plus_step[PERIOD_W-1:0];
                end else begin
                    period_next = slow_eff;
                end
            end

            if (dir_next) begin
                if (pha_reg == phb_reg) begin
                    pha_next = !pha_reg;
                end else begin
                    phb_next = !phb_reg;
                end
                pos_next = pos_reg + pos_t'(1);
            end else begin
                if (pha_reg == phb_reg) begin
                    phb_next = !phb_reg;
                end else begin
                    pha_next = !pha_reg;
                end
                pos_next = pos_reg - pos_t'(1);
            end
            stepped = 1'b1;
        end

        pos_wide = 64'(signed'(pos_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            period_reg  <= RST_SLOWEST_PERIOD;
            dir_reg     <= 1'b1;
            pha_reg     <= 1'b0;
            phb_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pos_reg     <= pos_next;
                period_reg  <= period_next;
                dir_reg     <= dir_next;
                pha_reg     <= pha_next;
                phb_reg     <= phb_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_period_reg  <= period_next;
            out_pha_reg     <= pha_next;
            out_phb_reg     <= phb_next;
            out_stepped_reg <= stepped;
            out_dir_reg     <= dir_next;
            out_pos_reg     <= pos_wide[31:0];
            out_rest_reg    <= rest;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_next_period      = out_period_reg;
    assign m_phase_a          = out_pha_reg;
    assign m_phase_b          = out_phb_reg;
    assign m_stepped          = out_stepped_reg;
    assign m_moving_forward   = out_dir_reg;
    assign m_current_position = out_pos_reg;
    assign m_at_rest          = out_rest_reg;

endmodule

`default_nettype wire

### rtl/stsg_checker.sv
// ----------------------------------------------------------------------------
// Stepper trapezoid step generator port checker
// Watches the top-level ports of the step generator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module stsg_checker
    import stsg_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [15:0]       m_next_period,
    input wire logic              m_stepped,
    input wire logic              m_at_rest,
    input wire logic [31:0]       m_current_position
);

    // The held position and timer reload must not change while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_position)
                                && $stable(m_next_period))
        else $error("stsg: stalled result changed");

    // The timer reload is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_period != '0)
        else $error("stsg: zero timer reload");

    // A motor at rest issues no step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_at_rest && m_stepped))
        else $error("stsg: step issued while at rest");

    // Reset leaves the output empty and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("stsg: result pending after reset");

endmodule

bind stepper_trapezoid_step_generator stsg_checker u_stsg_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_next_period      (m_next_period),
    .m_stepped          (m_stepped),
    .m_at_rest          (m_at_rest),
    .m_current_position (m_current_position)
);

`default_nettype wire

### tb/sv/stepper_trapezoid_step_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoid step generator testbench
// Drives timer ticks and position presets into the step generator and checks
// every result against a cycle-free model of the ramp kept in the bench, or
// against a result fixed in the script. A short scripted part covers reset,
// position wrap and the corner settings; random moves toward nearby targets
// under several register settings follow, with random stalls on both channels.
// ----------------------------------------------------------------------------

module stepper_trapezoid_step_generator_tb;

    import stsg_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;

    // Writes to this index hit no register and must be ignored.
    localparam cfg_index_t REG_UNUSED = 3'd7;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_PRESET = 1'b1
    } req_kind_e;

    typedef struct packed {
        period_t     next_period;
        logic        phase_a;
        logic        phase_b;
        logic        stepped;
        logic        forward;
        logic [31:0] position;
        logic        at_rest;
    } step_result_t;

    typedef struct packed {
        logic         is_cfg;
        cfg_index_t   idx;
        logic [15:0]  data;
        req_kind_e    kind;
        logic [31:0]  pos;
        logic         typed;
        step_result_t res;
    } script_row_t;

    typedef struct packed {
        period_t     slow;
        period_t     cruise;
        period_t     pstep;
        logic [15:0] shift_data;
        period_t     window;
        logic [15:0] span;
    } ramp_setting_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic        s_kind     = KIND_TICK;
    logic [31:0] s_position = '0;
    logic        s_typed    = 1'b0;
    step_result_t s_typed_result = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_next_period;
    logic        m_phase_a;
    logic        m_phase_b;
    logic        m_stepped;
    logic        m_moving_forward;
    logic [31:0] m_current_position;
    logic        m_at_rest;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    logic long_hold_go = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   stall_cycles = 0;
    int   mismatches   = 0;

    step_result_t expected_steps[$];
    script_row_t  directed_rows[$];

    // Bench copy of the ramp registers and state.
    period_t     slowest_q, cruise_q, pstep_q, window_q;
    shift_t      shift_q;
    period_t     period_q;
    logic [31:0] pos_q;
    logic        fwd_q, pha_q, phb_q;

    stepper_trapezoid_step_generator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_position         (s_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_next_period      (m_next_period),
        .m_phase_a          (m_phase_a),
        .m_phase_b          (m_phase_b),
        .m_stepped          (m_stepped),
        .m_moving_forward   (m_moving_forward),
        .m_current_position (m_current_position),
        .m_at_rest          (m_at_rest),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    function automatic step_result_t ramp_predict(input logic is_preset,
                                                  input logic [31:0] target);
        period_t      slow, cruise, brake;
        logic [16:0]  ramp_sum;
        logic [31:0]  stop_pos, dis;
        logic         stepped, rest;
        step_result_t res;
        slow   = (slowest_q == '0) ? MIN_PERIOD : slowest_q;
        cruise = (cruise_q == '0) ? MIN_PERIOD : cruise_q;
        if (cruise > slow) begin
            cruise = slow;
        end
        stepped = 1'b0;
        rest    = 1'b0;
        if (is_preset) begin
            pos_q = target;
        end else begin
            // A period above the slowest one means no braking distance at all.
            brake    = (period_q < slow) ? ((slow - period_q) >> shift_q) : '0;
            stop_pos = fwd_q ? pos_q + 32'(brake) : pos_q - 32'(brake);
            dis      = target - stop_pos;
            if (target == pos_q && brake <= window_q) begin
                period_q = slow;
                rest     = 1'b1;
            end else begin
                if (dis[31] == !fwd_q) begin
                    ramp_sum = 17'(cruise) + 17'(pstep_q);
                    if (17'(period_q) > ramp_sum) begin
                        if (dis != 32'd0 && dis != 32'd1 && dis != 32'hFFFF_FFFF) begin
                            period_q = period_q - pstep_q;
                        end
                    end else begin
                        period_q = cruise;
                    end
                end else begin
                    if (period_q == slow) begin
                        fwd_q = !fwd_q;
                    end
                    ramp_sum = 17'(period_q) + 17'(pstep_q);
                    if (ramp_sum < 17'(slow)) begin
                        period_q = period_q + pstep_q;
                    end else begin
                        period_q = slow;
                    end
                end
                if (fwd_q) begin
                    if (pha_q == phb_q) pha_q = !pha_q;
                    else phb_q = !phb_q;
                    pos_q = pos_q + 32'd1;
                end else begin
                    if (pha_q == phb_q) phb_q = !phb_q;
                    else pha_q = !pha_q;
                    pos_q = pos_q - 32'd1;
                end
                stepped = 1'b1;
            end
        end
        res.next_period = period_q;
        res.phase_a     = pha_q;
        res.phase_b     = phb_q;
        res.stepped     = stepped;
        res.forward     = fwd_q;
        res.position    = pos_q;
        res.at_rest     = rest;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    // Register writes, result checks and request predictions, all sampled at the edge.
    always @(posedge aclk) begin : scoreboard
        step_result_t got, want;
        if (!aresetn) begin
            slowest_q = RST_SLOWEST_PERIOD;
            cruise_q  = RST_CRUISE_PERIOD;
            pstep_q   = RST_PERIOD_STEP;
            shift_q   = RST_BRAKE_SHIFT;
            window_q  = RST_STOP_WINDOW;
            period_q  = RST_SLOWEST_PERIOD;
            pos_q     = '0;
            fwd_q     = 1'b1;
            pha_q     = 1'b0;
            phb_q     = 1'b0;
            expected_steps.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SLOWEST_PERIOD: slowest_q = cfg_data;
                    REG_CRUISE_PERIOD:  cruise_q  = cfg_data;
                    REG_PERIOD_STEP:    pstep_q   = cfg_data;
                    REG_BRAKE_SHIFT:    shift_q   = cfg_data[SHIFT_W-1:0];
                    REG_STOP_WINDOW:    window_q  = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_next_period, m_phase_a, m_phase_b, m_stepped, m_moving_forward,
                       m_current_position, m_at_rest};
                if (expected_steps.size() == 0) begin
                    $display("%0t: result expected none actual 0x%0h", $time, got);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_steps.pop_front();
                    check_field("next_period", 32'(want.next_period),
                                32'(got.next_period));
                    check_field("phase_a", 32'(want.phase_a), 32'(got.phase_a));
                    check_field("phase_b", 32'(want.phase_b), 32'(got.phase_b));
                    check_field("stepped", 32'(want.stepped), 32'(got.stepped));
                    check_field("moving_forward", 32'(want.forward), 32'(got.forward));
                    check_field("current_position", want.position, got.position);
                    check_field("at_rest", 32'(want.at_rest), 32'(got.at_rest));
                end
            end
            if (s_valid && s_ready) begin
                want = ramp_predict(s_kind == KIND_PRESET, s_position);
                expected_steps.push_back(s_typed ? s_typed_result : want);
            end
        end
    end

    // Result side: random stalls plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_go && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic script_row_t req_row(input req_kind_e kind, input logic [31:0] pos,
                                            input logic typed, input step_result_t res);
        script_row_t row;
        row        = '0;
        row.kind   = kind;
        row.pos    = pos;
        row.typed  = typed;
        row.res    = res;
        return row;
    endfunction

    function automatic script_row_t cfg_row(input cfg_index_t idx, input logic [15:0] data);
        script_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic logic [31:0] fresh_anchor();
        // Half of the anchors sit next to the signed wrap point.
        if ($urandom_range(1) == 0) return $urandom;
        return 32'h8000_0000 + $urandom_range(64) - 32'd32;
    endfunction

    task automatic send_request(input req_kind_e kind, input logic [31:0] pos,
                                input logic typed, input step_result_t res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_position     <= pos;
        s_typed        <= typed;
        s_typed_result <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering requests and wait until every expected result has been taken.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_steps.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no gap.
    task automatic cfg_write(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic write_regs(input ramp_setting_t set);
        drain();
        cfg_write(REG_SLOWEST_PERIOD, set.slow);
        cfg_write(REG_CRUISE_PERIOD, set.cruise);
        cfg_write(REG_PERIOD_STEP, set.pstep);
        cfg_write(REG_BRAKE_SHIFT, set.shift_data);
        cfg_write(REG_STOP_WINDOW, set.window);
        cfg_valid <= 1'b0;
    endtask

    // Mostly moves toward a target near the anchor, with some presets and stray targets.
    task automatic random_phase(input int items, input int span);
        int          sent, run, r, k;
        logic [31:0] anchor, target;
        anchor = fresh_anchor();
        send_request(KIND_PRESET, anchor, 1'b0, '0);
        sent = 1;
        while (sent < items) begin
            r = $urandom_range(99);
            if (r < 3) begin
                anchor = fresh_anchor();
                send_request(KIND_PRESET, anchor, 1'b0, '0);
                sent = sent + 1;
            end else if (r < 8) begin
                send_request(KIND_TICK, $urandom, 1'b0, '0);
                sent = sent + 1;
            end else begin
                target = anchor + $urandom_range(2 * span) - span;
                run    = $urandom_range(2 * span + 16, 1);
                for (k = 0; k < run && sent < items; k++) begin
                    send_request(KIND_TICK, target, 1'b0, '0);
                    sent = sent + 1;
                end
            end
        end
    endtask

    initial begin : stimulus
        script_row_t   row;
        ramp_setting_t set;
        int            p;

        // Reset state, then across the wrap from the largest position to the smallest.
        directed_rows.push_back(req_row(KIND_TICK, 32'h0, 1'b1,
            {16'd2000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0, 1'b1}));
        directed_rows.push_back(req_row(KIND_PRESET, 32'h7FFF_FFFF, 1'b1,
            {16'd2000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0}));
        directed_rows.push_back(req_row(KIND_TICK, 32'h7FFF_FFFF, 1'b1,
            {16'd2000, 1'b0, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1}));
        directed_rows.push_back(req_row(KIND_TICK, 32'h8000_0000, 1'b1,
            {16'd2000, 1'b1, 1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b0}));
        directed_rows.push_back(req_row(KIND_TICK, 32'h8000_0000, 1'b1,
            {16'd2000, 1'b1, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b1}));
        // The tick toward 2 lands exactly on the predicted stop point.
        directed_rows.push_back(req_row(KIND_PRESET, 32'd0, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd1000, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd2, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, -32'sd1000, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, -32'sd1000, 1'b0, '0));
        // Slowest period dropped below the running period.
        directed_rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_SLOWEST_PERIOD, 16'd100));
        directed_rows.push_back(req_row(KIND_TICK, 32'd3, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd3, 1'b0, '0));
        directed_rows.push_back(cfg_row(REG_STOP_WINDOW, 16'hFFFF));
        directed_rows.push_back(req_row(KIND_PRESET, 32'd5, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd5, 1'b0, '0));
        // Zero slowest and cruise periods, widest step and shift.
        directed_rows.push_back(cfg_row(REG_SLOWEST_PERIOD, 16'd0));
        directed_rows.push_back(cfg_row(REG_CRUISE_PERIOD, 16'd0));
        directed_rows.push_back(cfg_row(REG_PERIOD_STEP, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_BRAKE_SHIFT, 16'hFFFF));
        directed_rows.push_back(req_row(KIND_TICK, 32'd20, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd20, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, -32'sd20, 1'b0, '0));
        directed_rows.push_back(cfg_row(REG_SLOWEST_PERIOD, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_CRUISE_PERIOD, 16'hFFFF));
        directed_rows.push_back(cfg_row(REG_PERIOD_STEP, 16'd0));
        directed_rows.push_back(cfg_row(REG_BRAKE_SHIFT, 16'd0));
        directed_rows.push_back(cfg_row(REG_STOP_WINDOW, 16'd0));
        directed_rows.push_back(req_row(KIND_PRESET, 32'hFFFF_FFFF, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'hFFFF_FFFF, 1'b0, '0));
        directed_rows.push_back(req_row(KIND_TICK, 32'd0, 1'b0, '0));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!cfg_valid) drain();
                cfg_write(row.idx, row.data);
            end else begin
                if (cfg_valid) cfg_valid <= 1'b0;
                send_request(row.kind, row.pos, row.typed, row.res);
            end
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set = {16'd60, 16'd10, 16'd5, 16'd1, 16'd0, 16'd40};
                1: set = {16'd300, 16'd20, 16'd7, 16'd3, 16'd2, 16'd60};
                2: set = {16'd2000, 16'd200, 16'd4, 16'd2, 16'd0, 16'd300};
                3: set = {16'hFFFF, 16'hFFF0, 16'd1, 16'd15, 16'hFFFF, 16'd10};
                4: set = {16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8};
                5: set = {16'd40, 16'd3, 16'hFFFF, 16'd4, 16'd1, 16'd30};
                default: begin
                    set.slow       = 16'($urandom_range(200, 0));
                    set.cruise     = 16'($urandom_range(250, 0));
                    set.pstep      = 16'($urandom_range(20, 0));
                    set.shift_data = 16'($urandom_range(16'hFFFF, 0));
                    set.window     = 16'($urandom_range(8, 0));
                    set.span       = 16'd40;
                end
            endcase
            write_regs(set);
            if (p < 3) begin
                src_idle_pct  = 12;
                sink_idle_pct <= 81;
            end else if (p < 6) begin
                src_idle_pct  = 81;
                sink_idle_pct <= 12;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct <= 0;
            end
            // The result side stops for a long while here and the input backs up.
            if (p == 6) long_hold_go <= 1'b1;
            random_phase(PHASE_ITEMS, set.span);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
rtl/stsg_pkg.sv
rtl/stepper_trapezoid_step_generator.sv
rtl/stsg_checker.sv
tb/sv/stepper_trapezoid_step_generator_tb.sv
